// File: src/lsvs_pkg.sv
// Package with the shared types and constants of the LRU swap victim selector.
`timescale 1ns / 1ps
`default_nettype none

package lsvs_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    localparam int INDEX_W = 6;
    localparam int SIZE_W  = 16;
    localparam int AGE_W   = 31;

    localparam logic [SIZE_W-1:0] RESET_LIMIT       = 16'd2048;
    localparam logic [SIZE_W-1:0] MIN_HALVING_LIMIT = 16'd64;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef struct packed {
        logic present;
        logic shown;
        logic pinned;
        logic resident;
    } t_flags;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [AGE_W-1:0]  age;
    } t_data;

    typedef struct packed {
        t_flags flags;
        t_data  data;
    } t_entry;

endpackage

`default_nettype wire

// File: src/lsvs_table.sv
// Entry table: flag bits in flops cleared by reset, size and age in a memory.
`timescale 1ns / 1ps
`default_nettype none

module lsvs_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_wr_en,
    input  wire logic [lsvs_pkg::IDX_W-1:0] i_wr_addr,
    input  wire lsvs_pkg::t_entry          i_wr_entry,
    input  wire logic [lsvs_pkg::IDX_W-1:0] i_rd_addr,
    output lsvs_pkg::t_entry               o_rd_entry
);

    lsvs_pkg::t_flags r_flags [lsvs_pkg::ENTRIES];
    lsvs_pkg::t_data  r_mem   [lsvs_pkg::ENTRIES];
    lsvs_pkg::t_flags r_rd_flags;
    lsvs_pkg::t_data  r_rd_data;

    // Flags are cleared by reset so an unwritten entry is never present.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lsvs_pkg::ENTRIES; i++) begin
                r_flags[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_flags[i_wr_addr] <= i_wr_entry.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_flags <= r_flags[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = '{flags: r_rd_flags, data: r_rd_data};

endmodule

`default_nettype wire

// File: src/lru_swap_victim_select_top.sv
// Top level of the LRU swap victim selector: command port, scan sequencer, compare unit.
// A write beat leaves busy low; the next command may follow at once.
// A select raises busy while its scan passes run, each reading the entries in index order
// through the single table read port; a pass ends early at the first eligible never-swapped
// entry. With a start limit of 32768 at most ten passes run (one per limit down to 64).
// The result strobe is high for one cycle, the cycle in which busy drops; it cannot stall.
// Reset clears all entry flags and loads the start size limit with 2048.
`timescale 1ns / 1ps
`default_nettype none

module lru_swap_victim_select_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Command channel.
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [lsvs_pkg::INDEX_W-1:0]  i_entry_index,
    input  wire logic                          i_present,
    input  wire logic                          i_shown,
    input  wire logic                          i_pinned,
    input  wire logic                          i_resident,
    input  wire logic [lsvs_pkg::SIZE_W-1:0]   i_byte_count,
    input  wire logic [lsvs_pkg::AGE_W-1:0]    i_swap_age,
    input  wire logic [lsvs_pkg::SIZE_W-1:0]   i_lower_bound,
    // Result channel.
    output logic                               o_result_valid,
    output logic                               o_found,
    output logic [lsvs_pkg::INDEX_W-1:0]       o_victim_index,
    // Configuration channel: start size limit.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lsvs_pkg::SIZE_W-1:0]   i_cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                          r_state, n_state;
    logic [lsvs_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_rd_vld;
    logic [lsvs_pkg::IDX_W-1:0]      r_rd_idx;
    logic [lsvs_pkg::SIZE_W-1:0]     r_limit, n_limit;
    logic [lsvs_pkg::SIZE_W-1:0]     r_lower, n_lower;
    logic [lsvs_pkg::INDEX_W-1:0]    r_current, n_current;
    logic                            r_have, n_have;
    logic [lsvs_pkg::AGE_W-1:0]      r_best_age, n_best_age;
    logic [lsvs_pkg::IDX_W-1:0]      r_best_idx, n_best_idx;
    logic                            r_result_valid, n_result_valid;
    logic                            r_found, n_found;
    logic [lsvs_pkg::IDX_W-1:0]      r_victim, n_victim;
    logic [lsvs_pkg::SIZE_W-1:0]     r_start_limit;

    logic                            accept;
    logic                            wr_en;
    logic                            rd_en;
    logic [lsvs_pkg::IDX_W-1:0]      wr_addr;
    lsvs_pkg::t_entry                wr_entry;
    lsvs_pkg::t_entry                rd_entry;

    logic                            eligible;
    logic                            age_zero;
    logic                            better;
    logic                            last;
    logic                            have_after;
    logic [lsvs_pkg::IDX_W-1:0]      best_idx_after;
    logic [lsvs_pkg::SIZE_W-1:0]     half_limit;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // A write to an index past the end of the table is dropped.
    assign wr_addr  = lsvs_pkg::IDX_W'(i_entry_index);
    assign wr_en    = accept && (i_operation == lsvs_pkg::OP_WRITE) &&
                      (32'(i_entry_index) < 32'(lsvs_pkg::ENTRIES));
    assign wr_entry = '{flags: '{present:    i_present,
                                 shown:      i_shown,
                                 pinned:     i_pinned,
                                 resident:   i_resident},
                        data:  '{size: i_byte_count, age: i_swap_age}};

    // Reads are issued in index order; the entry comes back in the following cycle.
    assign rd_en = (r_state == ST_SCAN) &&
                   (r_cnt < lsvs_pkg::CNT_W'(lsvs_pkg::ENTRIES));

    lsvs_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (r_cnt[lsvs_pkg::IDX_W-1:0]),
        .o_rd_entry (rd_entry)
    );

    // The compare unit looks at one returned entry per cycle. An entry is a
    // candidate when it is in memory, free to go, not the current entry and big enough.
    assign eligible = r_rd_vld && (r_state == ST_SCAN) &&
                      rd_entry.flags.present && rd_entry.flags.resident &&
                      !rd_entry.flags.shown && !rd_entry.flags.pinned &&
                      (32'(r_rd_idx) != 32'(r_current)) &&
                      (rd_entry.data.size >= r_limit);
    assign age_zero = eligible && (rd_entry.data.age == '0);
    // Strict less-than keeps the lowest index on a tie.
    assign better   = eligible && (!r_have || (rd_entry.data.age < r_best_age));
    assign last     = r_rd_vld && (r_state == ST_SCAN) &&
                      (r_rd_idx == lsvs_pkg::IDX_W'(lsvs_pkg::ENTRIES - 1));
    assign have_after     = r_have || eligible;
    assign best_idx_after = better ? r_rd_idx : r_best_idx;
    assign half_limit     = r_limit >> 1;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_limit        = r_limit;
        n_lower        = r_lower;
        n_current      = r_current;
        n_have         = r_have;
        n_best_age     = r_best_age;
        n_best_idx     = r_best_idx;
        n_result_valid = 1'b0;
        n_found        = r_found;
        n_victim       = r_victim;

        case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == lsvs_pkg::OP_SELECT)) begin
                    n_state   = ST_SCAN;
                    n_cnt     = '0;
                    n_limit   = r_start_limit;
                    n_lower   = i_lower_bound;
                    n_current = i_entry_index;
                    n_have    = 1'b0;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (better) begin
                    n_best_age = rd_entry.data.age;
                    n_best_idx = r_rd_idx;
                end
                n_have = have_after;

                if (age_zero) begin
                    // A never-swapped candidate wins at once.
                    n_state        = ST_IDLE;
                    n_result_valid = 1'b1;
                    n_found        = 1'b1;
                    n_victim       = r_rd_idx;
                end else if (last) begin
                    if (have_after) begin
                        n_state        = ST_IDLE;
                        n_result_valid = 1'b1;
                        n_found        = 1'b1;
                        n_victim       = best_idx_after;
                    end else if ((r_limit <= lsvs_pkg::MIN_HALVING_LIMIT) ||
                                 (half_limit < r_lower)) begin
                        n_state        = ST_IDLE;
                        n_result_valid = 1'b1;
                        n_found        = 1'b0;
                        n_victim       = '0;
                    end else begin
                        // Nothing fit: halve the limit and scan the table again.
                        n_limit = half_limit;
                        n_cnt   = '0;
                        n_have  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_rd_vld       <= 1'b0;
            r_have         <= 1'b0;
            r_result_valid <= 1'b0;
            r_start_limit  <= lsvs_pkg::RESET_LIMIT;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_rd_vld       <= rd_en;
            r_have         <= n_have;
            r_result_valid <= n_result_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_start_limit <= i_cfg_data;
            end
        end
        r_rd_idx   <= r_cnt[lsvs_pkg::IDX_W-1:0];
        r_limit    <= n_limit;
        r_lower    <= n_lower;
        r_current  <= n_current;
        r_best_age <= n_best_age;
        r_best_idx <= n_best_idx;
        r_found    <= n_found;
        r_victim   <= n_victim;
    end

    assign o_result_valid = r_result_valid;
    assign o_found        = r_found;
    assign o_victim_index = lsvs_pkg::INDEX_W'(r_victim);

endmodule

`default_nettype wire

// File: src/lsvs_checker.sv
// Port-level checker for the LRU swap victim selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lsvs_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         i_operation,
    input wire logic                         o_result_valid,
    input wire logic                         o_found,
    input wire logic [lsvs_pkg::INDEX_W-1:0] o_victim_index
);

    // A write beat never makes the block busy.
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == lsvs_pkg::OP_WRITE)) |=> !busy)
        else $error("write beat left the block busy");

    // A select beat always starts a scan.
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == lsvs_pkg::OP_SELECT)) |=> busy)
        else $error("select beat did not start a scan");

    // A result comes out as the scan ends.
    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a scan");

    // A failed select reports index zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_victim_index == '0))
        else $error("failed select with nonzero index");

    // Two results never come back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

endmodule

bind lru_swap_victim_select_top lsvs_checker u_lsvs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_result_valid (o_result_valid),
    .o_found        (o_found),
    .o_victim_index (o_victim_index)
);

`default_nettype wire
